// ===== rtl/i2cms_pkg.sv =====
// Shared types, codes and helpers of the I2C master transfer sequencer.
package i2cms_pkg;

   localparam int BufferDepthDefault = 32;
   localparam int OutQueueDepth      = 3;
   localparam int CountWidth         = 6;
   localparam int CsrIndexWidth      = 2;
   localparam int RspWidth           = 39;

   localparam logic [CountWidth-1:0] CountMax = '1;

   localparam logic [7:0] BitAa  = 8'h04;
   localparam logic [7:0] BitSi  = 8'h08;
   localparam logic [7:0] BitSto = 8'h10;
   localparam logic [7:0] BitSta = 8'h20;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_START  = 2'd1,
      MODE_EVENT  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [7:0] {
      ST_START_SENT     = 8'h08,
      ST_RESTART_SENT   = 8'h10,
      ST_ADDR_W_ACK     = 8'h18,
      ST_ADDR_W_NACK    = 8'h20,
      ST_DATA_TX_ACK    = 8'h28,
      ST_DATA_TX_NACK   = 8'h30,
      ST_ARB_LOST       = 8'h38,
      ST_ADDR_R_ACK     = 8'h40,
      ST_ADDR_R_NACK    = 8'h48,
      ST_DATA_RX_ACK    = 8'h50,
      ST_DATA_RX_NACK   = 8'h58
   } status_code_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WRITE_LENGTH = 2'd0,
      CSR_READ_LENGTH  = 2'd1
   } csr_index_type;

   // Decoded result held between the store read and the output queue.
   typedef struct packed {
      logic [7:0] set_bits;
      logic [7:0] clear_bits;
      logic       tx_valid;
      logic       tx_from_store;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [4:0] rx_position;
   } stage_a_type;

   function automatic logic [CountWidth-1:0] bump(input logic [CountWidth-1:0] c);
      return (c < CountMax) ? c + 1'b1 : CountMax;
   endfunction

endpackage

// ===== rtl/i2cms_store.sv =====
// Transmit byte store: one write port and one registered read port.
module i2cms_store
   import i2cms_pkg::*;
#(
   parameter int BufferDepth = BufferDepthDefault
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(BufferDepth)-1:0] wr_addr,
   input  logic [7:0]                     wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(BufferDepth)-1:0] rd_addr,
   output logic [7:0]                     rd_data
);

   logic [7:0] mem [BufferDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/i2cms_seq.sv =====
// Status decode and transfer counters; drives the store ports and the decoded stage.
module i2cms_seq
   import i2cms_pkg::*;
#(
   parameter int BufferDepth = BufferDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  mode_type                       mode,
   input  logic [7:0]                     status_code,
   input  logic [7:0]                     bus_byte,
   input  logic [4:0]                     load_index,
   input  logic [7:0]                     load_value,
   input  logic [CountWidth-1:0]          write_length,
   input  logic [CountWidth-1:0]          read_length,
   output logic                           st_wr_en,
   output logic [$clog2(BufferDepth)-1:0] st_wr_addr,
   output logic [7:0]                     st_wr_data,
   output logic [$clog2(BufferDepth)-1:0] st_rd_addr,
   output logic                           a_valid,
   output stage_a_type                    a_stage
);

   localparam int AddrWidth = $clog2(BufferDepth);

   logic [CountWidth-1:0] sent_count_ff, sent_count_in;
   logic [CountWidth-1:0] received_count_ff, received_count_in;
   logic [CountWidth-1:0] received_bumped;
   logic                  a_valid_ff;
   stage_a_type           a_stage_ff, a_stage_in;

   assign received_bumped = bump(received_count_ff);
   assign st_rd_addr      = AddrWidth'(sent_count_ff);
   assign st_wr_addr      = AddrWidth'(load_index);
   assign st_wr_data      = load_value;

   always_comb begin
      sent_count_in     = sent_count_ff;
      received_count_in = received_count_ff;
      a_stage_in        = '0;
      st_wr_en          = 1'b0;
      if (accept) begin
         unique case (mode)
            MODE_LOAD: begin
               st_wr_en = (32'(load_index) < BufferDepth);
            end
            MODE_START: begin
               sent_count_in       = '0;
               received_count_in   = '0;
               a_stage_in.set_bits = BitSta;
            end
            MODE_EVENT: begin
               unique case (status_code)
                  ST_START_SENT, ST_RESTART_SENT, ST_ADDR_W_ACK: begin
                     a_stage_in.tx_valid      = 1'b1;
                     a_stage_in.tx_from_store = (32'(sent_count_ff) < BufferDepth);
                     sent_count_in            = bump(sent_count_ff);
                     a_stage_in.set_bits      = BitAa;
                     a_stage_in.clear_bits    = (status_code == ST_ADDR_W_ACK) ?
                                                BitSi : (BitSta | BitSi);
                  end
                  ST_ADDR_W_NACK, ST_DATA_TX_NACK, ST_ADDR_R_NACK: begin
                     a_stage_in.set_bits   = BitAa | BitSto;
                     a_stage_in.clear_bits = BitSi;
                  end
                  ST_DATA_TX_ACK: begin
                     // Writes first; pending reads restart before the last write.
                     a_stage_in.clear_bits = BitSi;
                     if (({1'b0, sent_count_ff} + 7'd1) < {1'b0, write_length}) begin
                        a_stage_in.tx_valid      = 1'b1;
                        a_stage_in.tx_from_store = (32'(sent_count_ff) < BufferDepth);
                        sent_count_in            = bump(sent_count_ff);
                        a_stage_in.set_bits      = BitAa;
                     end else if (received_count_ff < read_length) begin
                        a_stage_in.set_bits = BitSta;
                     end else if (sent_count_ff < write_length) begin
                        a_stage_in.tx_valid      = 1'b1;
                        a_stage_in.tx_from_store = (32'(sent_count_ff) < BufferDepth);
                        sent_count_in            = bump(sent_count_ff);
                        a_stage_in.set_bits      = BitAa;
                     end else begin
                        a_stage_in.set_bits = BitAa | BitSto;
                     end
                  end
                  ST_ARB_LOST: begin
                     sent_count_in         = '0;
                     received_count_in     = '0;
                     a_stage_in.set_bits   = BitAa | BitSta;
                     a_stage_in.clear_bits = BitSi;
                  end
                  ST_ADDR_R_ACK: begin
                     if (({1'b0, received_count_ff} + 7'd1) < {1'b0, read_length}) begin
                        a_stage_in.set_bits   = BitAa;
                        a_stage_in.clear_bits = BitSi;
                     end else begin
                        a_stage_in.clear_bits = BitAa | BitSi;
                     end
                  end
                  ST_DATA_RX_ACK: begin
                     a_stage_in.rx_valid    = 1'b1;
                     a_stage_in.rx_data     = bus_byte;
                     a_stage_in.rx_position = received_count_ff[4:0];
                     received_count_in      = received_bumped;
                     // The last expected byte is answered with a NACK.
                     if (({1'b0, received_bumped} + 7'd1) < {1'b0, read_length}) begin
                        a_stage_in.set_bits   = BitAa;
                        a_stage_in.clear_bits = BitSi;
                     end else begin
                        a_stage_in.clear_bits = BitAa | BitSi;
                     end
                  end
                  ST_DATA_RX_NACK: begin
                     a_stage_in.rx_valid    = 1'b1;
                     a_stage_in.rx_data     = bus_byte;
                     a_stage_in.rx_position = received_count_ff[4:0];
                     received_count_in      = received_bumped;
                     a_stage_in.set_bits    = BitAa | BitSto;
                     a_stage_in.clear_bits  = BitSi;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_count_ff     <= '0;
         received_count_ff <= '0;
         a_valid_ff        <= 1'b0;
      end else begin
         sent_count_ff     <= sent_count_in;
         received_count_ff <= received_count_in;
         a_valid_ff        <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_stage_ff <= a_stage_in;
   end

   assign a_valid = a_valid_ff;
   assign a_stage = a_stage_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_START) |=> (sent_count_ff == '0) && (received_count_ff == '0))
      else $error("start did not clear the transfer counts");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(sent_count_ff) && $stable(received_count_ff))
      else $error("transfer counts moved without an accepted beat");

   assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_EVENT) && (status_code == ST_DATA_RX_NACK)
      |=> (received_count_ff == bump($past(received_count_ff))) && a_stage_ff.rx_valid)
      else $error("final received byte not counted");

endmodule

// ===== rtl/i2cms_out_queue.sv =====
// Small result queue that decouples the response side from the decode pipeline.
module i2cms_out_queue
   import i2cms_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   input  logic [RspWidth-1:0]                   push_data,
   input  logic                                  pop,
   output logic                                  not_empty,
   output logic [$clog2(OutQueueDepth+1)-1:0]    count,
   output logic [RspWidth-1:0]                   head_data
);

   localparam int PtrWidth = $clog2(OutQueueDepth);
   localparam int CntWidth = $clog2(OutQueueDepth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(OutQueueDepth - 1);

   logic [RspWidth-1:0] entry_ff [OutQueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign count     = count_ff;
   assign head_data = entry_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= OutQueueDepth)
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      push && (32'(count_ff) == OutQueueDepth) |-> pop)
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("result queue underflow");

endmodule

// ===== rtl/i2c_master_transfer_sequencer_unit.sv =====
// I2C master transfer sequencer: takes one beat per clock while req_tready is high and
// returns one result beat for each, through a result queue fed by the registered decode
// stage. The transmit store is read through a registered port on acceptance; a three-entry
// result queue lets input keep flowing while results wait, and req_tready depends only
// on registered occupancy. Store entries are undefined until loaded; no clearing pass.
module i2c_master_transfer_sequencer_unit
   import i2cms_pkg::*;
#(
   parameter int BufferDepth = BufferDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // status_code[7:0], bus_byte[15:8], load_index[20:16], load_value[28:21]
   input  logic [31:0]              req_tdata,
   // mode[1:0]
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // set_bits[7:0], clear_bits[15:8], tx_valid[16], tx_byte[24:17],
   // rx_valid[25], rx_data[33:26], rx_position[38:34]
   output logic [39:0]              rsp_tdata,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CountWidth-1:0]    csr_data
);

   localparam int AddrWidth = $clog2(BufferDepth);
   localparam int QCntWidth = $clog2(OutQueueDepth + 1);

   logic [CountWidth-1:0] write_length_ff, read_length_ff;
   logic                  accept;
   logic                  st_wr_en;
   logic [AddrWidth-1:0]  st_wr_addr, st_rd_addr;
   logic [7:0]            st_wr_data, st_rd_data;
   logic                  a_valid;
   stage_a_type           a_stage;
   logic [7:0]            tx_byte;
   logic [RspWidth-1:0]   push_data, head_data;
   logic                  q_not_empty;
   logic [QCntWidth-1:0]  q_count;
   logic                  pop;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_length_ff <= '0;
         read_length_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WRITE_LENGTH: write_length_ff <= csr_data;
            CSR_READ_LENGTH:  read_length_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   i2cms_seq #(
      .BufferDepth(BufferDepth)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (mode_type'(req_tuser)),
      .status_code (req_tdata[7:0]),
      .bus_byte    (req_tdata[15:8]),
      .load_index  (req_tdata[20:16]),
      .load_value  (req_tdata[28:21]),
      .write_length(write_length_ff),
      .read_length (read_length_ff),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_addr  (st_rd_addr),
      .a_valid     (a_valid),
      .a_stage     (a_stage)
   );

   i2cms_store #(
      .BufferDepth(BufferDepth)
   ) u_store (
      .clock  (clock),
      .wr_en  (st_wr_en),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_en  (accept),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data)
   );

   // A send index past the end of the store delivers a zero byte.
   assign tx_byte = a_stage.tx_from_store ? st_rd_data : 8'h00;

   assign push_data = {a_stage.rx_position, a_stage.rx_data, a_stage.rx_valid,
                       tx_byte, a_stage.tx_valid, a_stage.clear_bits, a_stage.set_bits};

   // Room is reserved for the beat still in the decode stage.
   assign req_tready = (32'(q_count) + 32'(a_valid)) < OutQueueDepth;
   assign pop        = q_not_empty && rsp_tready;

   i2cms_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (a_valid),
      .push_data(push_data),
      .pop      (pop),
      .not_empty(q_not_empty),
      .count    (q_count),
      .head_data(head_data)
   );

   assign rsp_tvalid = q_not_empty;
   assign rsp_tdata  = {1'b0, head_data};

endmodule
